/* sv/bba_pkg.sv */
`default_nettype none
package bba_pkg;

    localparam int MIN_BLOCK_ORDER  = 5;
    localparam int MAX_POOL_ORDER   = 16;
    localparam int HEADER_BYTES     = 16;
    localparam int POOL_ORDER_RESET = 16;

    localparam int SLOT_W = MAX_POOL_ORDER - MIN_BLOCK_ORDER;
    localparam int SLOTS  = 1 << SLOT_W;
    localparam int LEVELS = SLOT_W + 1;
    localparam int LVL_W  = 4;
    localparam int ORD_W  = 5;
    localparam int SIZE_W = MAX_POOL_ORDER + 1;
    localparam int CNT_W  = 12;
    localparam int ADDR_W = 16;

    localparam logic [1:0] REG_POOL_ORDER = 2'd0;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FAIL    = 2'd1,
        ST_IGNORED = 2'd2
    } t_status;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_opcode;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_POP,
        S_A_SPLIT,
        S_A_FIN,
        S_F_CHK,
        S_F_BUD,
        S_F_WALK,
        S_F_PUSH,
        S_DONE
    } t_state;

    // One word of block bookkeeping per minimum-size slot.
    typedef struct packed {
        logic              used;
        logic              free;
        logic [LVL_W-1:0]  order;
        logic [SLOT_W-1:0] link;
    } t_entry;

    typedef struct packed {
        t_status           status;
        logic [ADDR_W-1:0] granted;
        logic [SIZE_W-1:0] available;
        logic [SIZE_W-1:0] lowest;
        logic [31:0]       allocs;
        logic [31:0]       frees;
        logic [SIZE_W-1:0] largest;
        logic [SIZE_W-1:0] smallest;
        logic [CNT_W-1:0]  total;
    } t_result;

endpackage
`default_nettype wire

/* sv/bba_if.sv */
`default_nettype none
interface bba_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [15:0] request_size;
    logic [15:0] user_address;

    modport source(output valid, opcode, request_size, user_address, input ready);
    modport sink(input valid, opcode, request_size, user_address, output ready);
endinterface

interface bba_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] granted_address;
    logic [16:0] available_bytes;
    logic [16:0] lowest_available;
    logic [31:0] allocations_done;
    logic [31:0] frees_done;
    logic [16:0] largest_free;
    logic [16:0] smallest_free;
    logic [11:0] free_block_total;

    modport source(output valid, status, granted_address, available_bytes,
                   lowest_available, allocations_done, frees_done, largest_free,
                   smallest_free, free_block_total, input ready);
    modport sink(input valid, status, granted_address, available_bytes,
                 lowest_available, allocations_done, frees_done, largest_free,
                 smallest_free, free_block_total, output ready);
endinterface
`default_nettype wire

/* sv/bba_mem.sv */
`default_nettype none
module bba_mem (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [bba_pkg::SLOT_W-1:0]     i_waddr,
    input  bba_pkg::t_entry                i_wdata,
    input  logic                           i_re,
    input  logic [bba_pkg::SLOT_W-1:0]     i_raddr,
    output bba_pkg::t_entry                o_rdata
);
    import bba_pkg::*;

    t_entry r_mem [SLOTS];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

/* sv/bba_core.sv */
`default_nettype none
module bba_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_init,
    input  logic [bba_pkg::ORD_W-1:0]       i_pool_order,
    input  logic                            i_start,
    input  logic                            i_opcode,
    input  logic [bba_pkg::ADDR_W-1:0]      i_size,
    input  logic [bba_pkg::ADDR_W-1:0]      i_addr,
    output logic                            o_ready,
    input  logic                            i_out_free,
    output logic                            o_done,
    output bba_pkg::t_result                o_result
);
    import bba_pkg::*;

    t_state            r_state, n_state;
    logic [SLOT_W-1:0] r_clr, n_clr;
    logic [SLOT_W-1:0] r_head [LEVELS];
    logic [SLOT_W-1:0] n_head [LEVELS];
    logic [CNT_W-1:0]  r_count [LEVELS];
    logic [CNT_W-1:0]  n_count [LEVELS];
    logic [CNT_W-1:0]  r_total, n_total;
    logic [SIZE_W-1:0] r_avail, n_avail;
    logic [SIZE_W-1:0] r_lowest, n_lowest;
    logic [31:0]       r_allocs, n_allocs;
    logic [31:0]       r_frees, n_frees;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [SLOT_W-1:0] r_b, n_b;
    logic [SLOT_W-1:0] r_cur, n_cur;
    logic [SLOT_W-1:0] r_blink, n_blink;
    logic [LVL_W-1:0]  r_lvl, n_lvl;
    logic [LVL_W-1:0]  r_k, n_k;
    logic [SIZE_W-1:0] r_freed, n_freed;
    t_status           r_status, n_status;
    logic [ADDR_W-1:0] r_granted, n_granted;

    logic              m_we, m_re;
    logic [SLOT_W-1:0] m_waddr, m_raddr;
    t_entry            m_wdata, rd;

    logic [SIZE_W-1:0] pool_size, needed, need_m1, blk_size;
    logic [LVL_W-1:0]  top_lvl, a_lvl, k_sel, hsel;
    logic [ORD_W-1:0]  ord, msb_pos;
    logic [LEVELS-1:0] nz, lvl_mask, avail_mask;
    logic              alloc_bad, k_found, free_bad;
    logic [ADDR_W-1:0] off;
    logic [SLOT_W-1:0] f_slot, hd, c_bud, m_slot, m_bud, split_addr;
    logic [LVL_W-1:0]  m_lvl;
    logic              c_more, m_more, bud_ok, hit_head, walk_hit;
    logic              cnt_inc, cnt_dec;
    logic [LVL_W-1:0]  cidx;
    logic [SIZE_W-1:0] largest, smallest;
    logic              seen;

    bba_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_re    (m_re),
        .i_raddr (m_raddr),
        .o_rdata (rd)
    );

    // Request decode.
    always_comb begin
        pool_size = SIZE_W'(1) << i_pool_order;
        top_lvl   = LVL_W'(i_pool_order - ORD_W'(MIN_BLOCK_ORDER));
        needed    = SIZE_W'(i_size) + SIZE_W'(HEADER_BYTES);
        need_m1   = needed - SIZE_W'(1);
        msb_pos   = '0;
        for (int i = 0; i < SIZE_W; i++) begin
            if (need_m1[i]) msb_pos = ORD_W'(i + 1);
        end
        ord = (msb_pos < ORD_W'(MIN_BLOCK_ORDER)) ? ORD_W'(MIN_BLOCK_ORDER) : msb_pos;
        alloc_bad = (i_size == '0) || (ord > i_pool_order);
        a_lvl = LVL_W'(ord - ORD_W'(MIN_BLOCK_ORDER));
        for (int l = 0; l < LEVELS; l++) begin
            nz[l] = (r_count[l] != '0);
        end
        lvl_mask   = {LEVELS{1'b1}} << a_lvl;
        avail_mask = nz & lvl_mask;
        k_found    = |avail_mask;
        k_sel      = '0;
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if (avail_mask[l]) k_sel = LVL_W'(l);
        end
        off      = i_addr - ADDR_W'(HEADER_BYTES);
        f_slot   = off[ADDR_W-1:MIN_BLOCK_ORDER];
        free_bad = (i_addr < ADDR_W'(HEADER_BYTES))
                || ({1'b0, off} >= pool_size)
                || (off[MIN_BLOCK_ORDER-1:0] != '0);
    end

    // Free-list head selection and merge helpers.
    always_comb begin
        unique case (r_state)
            S_IDLE:    hsel = k_sel;
            S_A_SPLIT: hsel = r_k;
            default:   hsel = r_lvl;
        endcase
        hd         = r_head[hsel];
        split_addr = r_slot | (SLOT_W'(1) << r_k);
        c_bud      = r_slot ^ (SLOT_W'(1) << rd.order);
        c_more     = rd.order < top_lvl;
        bud_ok     = rd.free && (rd.order == r_lvl);
        hit_head   = (hd == r_b);
        walk_hit   = (rd.link == r_b);
        m_slot     = r_slot & ~(SLOT_W'(1) << r_lvl);
        m_lvl      = r_lvl + LVL_W'(1);
        m_more     = m_lvl < top_lvl;
        m_bud      = m_slot ^ (SLOT_W'(1) << m_lvl);
        blk_size   = SIZE_W'(1) << (ORD_W'(r_lvl) + ORD_W'(MIN_BLOCK_ORDER));
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == '0) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    if (i_opcode == OP_FREE) begin
                        n_state = free_bad ? S_DONE : S_F_CHK;
                    end else begin
                        n_state = (alloc_bad || !k_found) ? S_DONE : S_A_POP;
                    end
                end
            end
            S_A_POP, S_A_SPLIT: begin
                n_state = (r_k == r_lvl) ? S_A_FIN : S_A_SPLIT;
            end
            S_A_FIN: n_state = S_DONE;
            S_F_CHK: begin
                if (!rd.used) n_state = S_DONE;
                else          n_state = c_more ? S_F_BUD : S_F_PUSH;
            end
            S_F_BUD: begin
                if (!bud_ok)       n_state = S_F_PUSH;
                else if (hit_head) n_state = m_more ? S_F_BUD : S_F_PUSH;
                else               n_state = S_F_WALK;
            end
            S_F_WALK: begin
                if (walk_hit) n_state = m_more ? S_F_BUD : S_F_PUSH;
            end
            S_F_PUSH: n_state = S_DONE;
            S_DONE: begin
                if (i_out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        n_clr     = r_clr;
        n_head    = r_head;
        n_count   = r_count;
        n_total   = r_total;
        n_avail   = r_avail;
        n_lowest  = r_lowest;
        n_allocs  = r_allocs;
        n_frees   = r_frees;
        n_slot    = r_slot;
        n_b       = r_b;
        n_cur     = r_cur;
        n_blink   = r_blink;
        n_lvl     = r_lvl;
        n_k       = r_k;
        n_freed   = r_freed;
        n_status  = r_status;
        n_granted = r_granted;
        m_we      = 1'b0;
        m_waddr   = r_slot;
        m_wdata   = '0;
        m_re      = 1'b0;
        m_raddr   = r_slot;
        cnt_inc   = 1'b0;
        cnt_dec   = 1'b0;
        cidx      = r_lvl;

        unique case (r_state)
            S_CLEAR: begin
                m_we    = 1'b1;
                m_waddr = r_clr;
                n_clr   = r_clr - SLOT_W'(1);
                if (r_clr == '0) begin
                    // Last sweep word: slot zero becomes the whole free pool.
                    m_wdata = '{used: 1'b0, free: 1'b1, order: top_lvl, link: '0};
                    for (int l = 0; l < LEVELS; l++) begin
                        n_head[l]  = '0;
                        n_count[l] = '0;
                    end
                    n_count[top_lvl] = CNT_W'(1);
                    n_total  = CNT_W'(1);
                    n_avail  = pool_size;
                    n_lowest = pool_size;
                    n_allocs = '0;
                    n_frees  = '0;
                end
            end
            S_IDLE: begin
                n_granted = '0;
                if (i_start) begin
                    if (i_opcode == OP_FREE) begin
                        n_status = ST_IGNORED;
                        n_slot   = f_slot;
                        m_re     = !free_bad;
                        m_raddr  = f_slot;
                    end else begin
                        n_status = ST_FAIL;
                        n_k      = k_sel;
                        n_lvl    = a_lvl;
                        n_slot   = hd;
                        m_re     = !(alloc_bad || !k_found);
                        m_raddr  = hd;
                    end
                end
            end
            S_A_POP: begin
                n_head[r_k] = rd.link;
                cidx        = r_k;
                cnt_dec     = 1'b1;
                n_k         = r_k - LVL_W'(1);
            end
            S_A_SPLIT: begin
                m_we        = 1'b1;
                m_waddr     = split_addr;
                m_wdata     = '{used: 1'b0, free: 1'b1, order: r_k, link: hd};
                n_head[r_k] = split_addr;
                cidx        = r_k;
                cnt_inc     = 1'b1;
                n_k         = r_k - LVL_W'(1);
            end
            S_A_FIN: begin
                m_we      = 1'b1;
                m_wdata   = '{used: 1'b1, free: 1'b0, order: r_lvl, link: '0};
                n_avail   = r_avail - blk_size;
                n_lowest  = (n_avail < r_lowest) ? n_avail : r_lowest;
                n_allocs  = r_allocs + 32'd1;
                n_status  = ST_OK;
                n_granted = {r_slot, {MIN_BLOCK_ORDER{1'b0}}} + ADDR_W'(HEADER_BYTES);
            end
            S_F_CHK: begin
                if (rd.used) begin
                    m_we    = 1'b1;
                    m_wdata = '{used: 1'b0, free: 1'b0, order: rd.order, link: rd.link};
                    n_lvl   = rd.order;
                    n_freed = SIZE_W'(1) << (ORD_W'(rd.order) + ORD_W'(MIN_BLOCK_ORDER));
                    n_b     = c_bud;
                    m_re    = c_more;
                    m_raddr = c_bud;
                end
            end
            S_F_BUD: begin
                if (bud_ok) begin
                    m_we    = 1'b1;
                    m_waddr = r_b;
                    m_wdata = '{used: 1'b0, free: 1'b0, order: rd.order, link: rd.link};
                    n_blink = rd.link;
                    if (hit_head) begin
                        n_head[r_lvl] = rd.link;
                        cnt_dec = 1'b1;
                        n_slot  = m_slot;
                        n_lvl   = m_lvl;
                        n_b     = m_bud;
                        m_re    = m_more;
                        m_raddr = m_bud;
                    end else begin
                        n_cur   = hd;
                        m_re    = 1'b1;
                        m_raddr = hd;
                    end
                end
            end
            S_F_WALK: begin
                if (walk_hit) begin
                    // Bypass the buddy: predecessor now points past it.
                    m_we    = 1'b1;
                    m_waddr = r_cur;
                    m_wdata = '{used: rd.used, free: rd.free, order: rd.order,
                                link: r_blink};
                    cnt_dec = 1'b1;
                    n_slot  = m_slot;
                    n_lvl   = m_lvl;
                    n_b     = m_bud;
                    m_re    = m_more;
                    m_raddr = m_bud;
                end else begin
                    n_cur   = rd.link;
                    m_re    = 1'b1;
                    m_raddr = rd.link;
                end
            end
            S_F_PUSH: begin
                m_we          = 1'b1;
                m_wdata       = '{used: 1'b0, free: 1'b1, order: r_lvl, link: hd};
                n_head[r_lvl] = r_slot;
                cnt_inc       = 1'b1;
                n_avail       = r_avail + r_freed;
                n_frees       = r_frees + 32'd1;
                n_status      = ST_OK;
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase

        if (cnt_dec) begin
            n_count[cidx] = r_count[cidx] - CNT_W'(1);
            n_total       = r_total - CNT_W'(1);
        end
        if (cnt_inc) begin
            n_count[cidx] = r_count[cidx] + CNT_W'(1);
            n_total       = r_total + CNT_W'(1);
        end
    end

    // Result assembly.
    always_comb begin
        largest  = '0;
        smallest = '0;
        seen     = 1'b0;
        for (int l = 0; l < LEVELS; l++) begin
            if (nz[l]) begin
                if (!seen) smallest = SIZE_W'(1) << (l + MIN_BLOCK_ORDER);
                seen    = 1'b1;
                largest = SIZE_W'(1) << (l + MIN_BLOCK_ORDER);
            end
        end
        o_result = '{status: r_status, granted: r_granted, available: r_avail,
                     lowest: r_lowest, allocs: r_allocs, frees: r_frees,
                     largest: largest, smallest: smallest, total: r_total};
        o_ready  = (r_state == S_IDLE);
        o_done   = (r_state == S_DONE) && i_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_init) begin
            r_state <= S_CLEAR;
            r_clr   <= '1;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head    <= n_head;
        r_count   <= n_count;
        r_total   <= n_total;
        r_avail   <= n_avail;
        r_lowest  <= n_lowest;
        r_allocs  <= n_allocs;
        r_frees   <= n_frees;
        r_slot    <= n_slot;
        r_b       <= n_b;
        r_cur     <= n_cur;
        r_blink   <= n_blink;
        r_lvl     <= n_lvl;
        r_k       <= n_k;
        r_freed   <= n_freed;
        r_status  <= n_status;
        r_granted <= n_granted;
    end
endmodule
`default_nettype wire

/* sv/buddy_block_allocator.sv */
// An allocate pops a free block, splits once per order above the one needed, then finishes;
// a free checks the block, examines each buddy, walks list nodes to unlink, then pushes.
// A rejected allocate or out-of-range free is answered at once, a stray free after the check.
// Throughput: one beat in flight; the next beat is taken once the result enters the output
// register, so the walk through the bookkeeping memory sets the rate.
// Reset (synchronous, active low) and any pool_order write start a sweep of every word of the
// bookkeeping memory during which no request beat is accepted.
`default_nettype none
module buddy_block_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bba_req_if.sink     i_req,
    bba_rsp_if.source   o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bba_pkg::*;

    // Pool order register. Writes are clamped into the legal range and
    // restart the allocator with the whole pool as one free block.
    logic [ORD_W-1:0] r_pool_order, n_pool_order;
    logic             cfg_wr;

    // Output register: decouples the result beat from the next request.
    logic             r_ovalid;
    t_result          r_result;
    t_result          core_result;
    logic             core_done, core_ready, out_free;

    always_comb begin
        cfg_wr = psel && penable && pwrite && (paddr == REG_POOL_ORDER);
        if (pwdata[ORD_W-1:0] < ORD_W'(MIN_BLOCK_ORDER)) begin
            n_pool_order = ORD_W'(MIN_BLOCK_ORDER);
        end else if (pwdata[ORD_W-1:0] > ORD_W'(MAX_POOL_ORDER)) begin
            n_pool_order = ORD_W'(MAX_POOL_ORDER);
        end else begin
            n_pool_order = pwdata[ORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_order <= ORD_W'(POOL_ORDER_RESET);
        end else if (cfg_wr) begin
            r_pool_order <= n_pool_order;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == REG_POOL_ORDER) ? {{(32 - ORD_W){1'b0}}, r_pool_order} : '0;

    assign out_free = !r_ovalid || o_rsp.ready;

    bba_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_init       (cfg_wr),
        .i_pool_order (r_pool_order),
        .i_start      (i_req.valid),
        .i_opcode     (i_req.opcode),
        .i_size       (i_req.request_size),
        .i_addr       (i_req.user_address),
        .o_ready      (core_ready),
        .i_out_free   (out_free),
        .o_done       (core_done),
        .o_result     (core_result)
    );

    assign i_req.ready = core_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (core_done) begin
            r_ovalid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_done) begin
            r_result <= core_result;
        end
    end

    assign o_rsp.valid            = r_ovalid;
    assign o_rsp.status           = r_result.status;
    assign o_rsp.granted_address  = r_result.granted;
    assign o_rsp.available_bytes  = r_result.available;
    assign o_rsp.lowest_available = r_result.lowest;
    assign o_rsp.allocations_done = r_result.allocs;
    assign o_rsp.frees_done       = r_result.frees;
    assign o_rsp.largest_free     = r_result.largest;
    assign o_rsp.smallest_free    = r_result.smallest;
    assign o_rsp.free_block_total = r_result.total;

    // The low-water mark can never sit above the current free byte count.
    a_lowest_le_avail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.lowest_available <= o_rsp.available_bytes))
        else $error("lowest_available above available_bytes");

    // A failed or ignored request never hands out an address.
    a_no_grant_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status != ST_OK)) |-> (o_rsp.granted_address == '0))
        else $error("granted address on failed request");

    // Largest and smallest free sizes stay ordered.
    a_size_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.largest_free >= o_rsp.smallest_free))
        else $error("largest_free below smallest_free");
endmodule
`default_nettype wire
